/* rtl/linear_point_by_point_interpolator_top_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the point-by-point line interpolator
// Concurrent checks sampled on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LINEAR_POINT_BY_POINT_INTERPOLATOR_TOP_DEFINES_SVH
`define LINEAR_POINT_BY_POINT_INTERPOLATOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define LPI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lpi_pkg.sv */
// ---------------------------------------------------------------------------
// lpi_pkg
// Shared codes, widths and types of the point-by-point line interpolator.
// ---------------------------------------------------------------------------
`default_nettype none

package lpi_pkg;

    // Item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    // Move axis codes
    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_X_STEP_SIZE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_STEP_SIZE = 1'b1;

    localparam int STEP_W = 16;
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd10;

    // Deviation accumulator wraps at this width
    localparam int DEV_W = 52;

    typedef enum logic [1:0] {
        QUAD_1 = 2'd0,
        QUAD_2 = 2'd1,
        QUAD_3 = 2'd2,
        QUAD_4 = 2'd3
    } quad_t;

    typedef struct packed {
        logic moved;
        logic move_axis;
        logic move_negative;
        logic last;
    } move_flags_t;

endpackage

`default_nettype wire

/* rtl/linear_point_by_point_interpolator_top.sv */
// ---------------------------------------------------------------------------
// linear_point_by_point_interpolator_top
// Flow: input register, then result register for a step result; a load gives no result.
// Throughput: one beat per cycle; a step waits in the input register while a result is held.
// Reset: async, clears the segment (no segment, position zero), step sizes return to 10.
// ---------------------------------------------------------------------------
`default_nettype none

module linear_point_by_point_interpolator_top #(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [lpi_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [lpi_pkg::STEP_W-1:0]            cfg_wdata,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  func,
    input  wire logic signed [COORD_WIDTH-1:0]         seg_start_x,
    input  wire logic signed [COORD_WIDTH-1:0]         seg_start_y,
    input  wire logic signed [COORD_WIDTH-1:0]         seg_end_x,
    input  wire logic signed [COORD_WIDTH-1:0]         seg_end_y,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic                                       moved,
    output logic                                       move_axis,
    output logic                                       move_negative,
    output logic signed [COORD_WIDTH-1:0]              pos_x,
    output logic signed [COORD_WIDTH-1:0]              pos_y,
    output logic                                       last
);

    logic [lpi_pkg::STEP_W-1:0] x_step_reg, x_step_next;
    logic [lpi_pkg::STEP_W-1:0] y_step_reg, y_step_next;

    logic                          item_valid;
    logic                          item_func;
    logic signed [COORD_WIDTH-1:0] item_start_x;
    logic signed [COORD_WIDTH-1:0] item_start_y;
    logic signed [COORD_WIDTH-1:0] item_end_x;
    logic signed [COORD_WIDTH-1:0] item_end_y;
    logic                          exec_fire;
    logic                          capture;
    lpi_pkg::move_flags_t          core_flags;
    logic signed [COORD_WIDTH-1:0] core_pos_x;
    logic signed [COORD_WIDTH-1:0] core_pos_y;
    lpi_pkg::move_flags_t          out_flags;

    // Step size registers
    always_comb
    begin
        x_step_next = x_step_reg;
        y_step_next = y_step_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                lpi_pkg::CFG_X_STEP_SIZE: x_step_next = cfg_wdata;
                lpi_pkg::CFG_Y_STEP_SIZE: y_step_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_step_reg <= lpi_pkg::STEP_RESET;
            y_step_reg <= lpi_pkg::STEP_RESET;
        end
        else
        begin
            x_step_reg <= x_step_next;
            y_step_reg <= y_step_next;
        end
    end

    // A load never needs the result slot; a step advances once the slot frees
    assign exec_fire = item_valid
                    && ((item_func == lpi_pkg::FUNC_LOAD) || !out_valid || out_ready);
    assign capture   = exec_fire && (item_func == lpi_pkg::FUNC_STEP);

    lpi_in_stage #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .seg_start_x  (seg_start_x),
        .seg_start_y  (seg_start_y),
        .seg_end_x    (seg_end_x),
        .seg_end_y    (seg_end_y),
        .advance      (exec_fire),
        .item_valid   (item_valid),
        .item_func    (item_func),
        .item_start_x (item_start_x),
        .item_start_y (item_start_y),
        .item_end_x   (item_end_x),
        .item_end_y   (item_end_y)
    );

    lpi_core #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (exec_fire),
        .func        (item_func),
        .seg_start_x (item_start_x),
        .seg_start_y (item_start_y),
        .seg_end_x   (item_end_x),
        .seg_end_y   (item_end_y),
        .x_step_size (x_step_reg),
        .y_step_size (y_step_reg),
        .flags       (core_flags),
        .step_pos_x  (core_pos_x),
        .step_pos_y  (core_pos_y)
    );

    lpi_out_stage #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .capture   (capture),
        .flags_in  (core_flags),
        .pos_x_in  (core_pos_x),
        .pos_y_in  (core_pos_y),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .flags_out (out_flags),
        .pos_x_out (pos_x),
        .pos_y_out (pos_y)
    );

    assign moved         = out_flags.moved;
    assign move_axis     = out_flags.move_axis;
    assign move_negative = out_flags.move_negative;
    assign last          = out_flags.last;

endmodule

`default_nettype wire

/* rtl/lpi_in_stage.sv */
// ---------------------------------------------------------------------------
// lpi_in_stage
// Input register: holds one accepted beat until the core consumes it.
// ---------------------------------------------------------------------------
`default_nettype none

module lpi_in_stage #(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          func,
    input  wire logic signed [COORD_WIDTH-1:0] seg_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] seg_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] seg_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] seg_end_y,
    input  wire logic                          advance,
    output logic                               item_valid,
    output logic                               item_func,
    output logic signed [COORD_WIDTH-1:0]      item_start_x,
    output logic signed [COORD_WIDTH-1:0]      item_start_y,
    output logic signed [COORD_WIDTH-1:0]      item_end_x,
    output logic signed [COORD_WIDTH-1:0]      item_end_y
);

    logic                          valid_reg;
    logic                          valid_next;
    logic                          func_reg;
    logic signed [COORD_WIDTH-1:0] start_x_reg;
    logic signed [COORD_WIDTH-1:0] start_y_reg;
    logic signed [COORD_WIDTH-1:0] end_x_reg;
    logic signed [COORD_WIDTH-1:0] end_y_reg;
    logic                          take;

    assign in_ready = !valid_reg || advance;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            func_reg    <= func;
            start_x_reg <= seg_start_x;
            start_y_reg <= seg_start_y;
            end_x_reg   <= seg_end_x;
            end_y_reg   <= seg_end_y;
        end
    end

    assign item_valid   = valid_reg;
    assign item_func    = func_reg;
    assign item_start_x = start_x_reg;
    assign item_start_y = start_y_reg;
    assign item_end_x   = end_x_reg;
    assign item_end_y   = end_y_reg;

endmodule

`default_nettype wire

/* rtl/lpi_core.sv */
// ---------------------------------------------------------------------------
// lpi_core
// Segment state and the combinational load / step datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module lpi_core #(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             fire,
    input  wire logic                             func,
    input  wire logic signed [COORD_WIDTH-1:0]    seg_start_x,
    input  wire logic signed [COORD_WIDTH-1:0]    seg_start_y,
    input  wire logic signed [COORD_WIDTH-1:0]    seg_end_x,
    input  wire logic signed [COORD_WIDTH-1:0]    seg_end_y,
    input  wire logic [lpi_pkg::STEP_W-1:0]       x_step_size,
    input  wire logic [lpi_pkg::STEP_W-1:0]       y_step_size,
    output lpi_pkg::move_flags_t                  flags,
    output logic signed [COORD_WIDTH-1:0]         step_pos_x,
    output logic signed [COORD_WIDTH-1:0]         step_pos_y
);

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int SIZE_W = lpi_pkg::STEP_W + 1;
    localparam int INC_W  = COORD_WIDTH + lpi_pkg::STEP_W + 2;
    localparam int SUM_W  = COORD_WIDTH + lpi_pkg::STEP_W + 1;
    localparam int DEV_W  = lpi_pkg::DEV_W;

    localparam logic signed [SUM_W-1:0] COORD_MAX =
        {{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] COORD_MIN =
        {{(SUM_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

    // Segment state
    logic signed [COORD_WIDTH-1:0] pos_x_reg,    pos_x_next;
    logic signed [COORD_WIDTH-1:0] pos_y_reg,    pos_y_next;
    logic signed [COORD_WIDTH-1:0] target_x_reg, target_x_next;
    logic signed [COORD_WIDTH-1:0] target_y_reg, target_y_next;
    logic signed [DEV_W-1:0]       dev_reg,      dev_next;
    logic signed [INC_W-1:0]       x_inc_reg,    x_inc_next;
    logic signed [INC_W-1:0]       y_inc_reg,    y_inc_next;
    lpi_pkg::quad_t                quad_reg,     quad_next;
    logic                          active_reg,   active_next;
    logic                          first_reg,    first_next;

    // Load path
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic                     dx_neg;
    logic                     dy_neg;
    logic signed [SIZE_W-1:0] x_size;
    logic signed [SIZE_W-1:0] y_size;
    logic signed [SIZE_W-1:0] x_size_dir;
    logic signed [SIZE_W-1:0] y_size_dir;
    logic signed [INC_W-1:0]  x_inc_load;
    logic signed [INC_W-1:0]  y_inc_load;
    lpi_pkg::quad_t           quad_load;

    // Step path
    logic                     x_neg;
    logic                     y_neg;
    logic                     move_y;
    logic signed [SUM_W-1:0]  x_ext;
    logic signed [SUM_W-1:0]  y_ext;
    logic signed [SUM_W-1:0]  x_sz;
    logic signed [SUM_W-1:0]  y_sz;
    logic signed [SUM_W-1:0]  nx;
    logic signed [SUM_W-1:0]  ny;
    logic signed [SUM_W-1:0]  tx_ext;
    logic signed [SUM_W-1:0]  ty_ext;
    logic                     passed;
    logic signed [COORD_WIDTH-1:0] sat_x;
    logic signed [COORD_WIDTH-1:0] sat_y;
    logic signed [DEV_W-1:0]  dev_step;

    // ---------------- load ----------------
    always_comb
    begin
        dx     = DIFF_W'(seg_end_x) - DIFF_W'(seg_start_x);
        dy     = DIFF_W'(seg_end_y) - DIFF_W'(seg_start_y);
        dx_neg = dx[DIFF_W-1];
        dy_neg = dy[DIFF_W-1];
        x_size = SIZE_W'(x_step_size);
        y_size = SIZE_W'(y_step_size);
        x_size_dir = dx_neg ? -x_size : x_size;
        // y increment carries the minus sign of the deviation term
        y_size_dir = dy_neg ? y_size : -y_size;
        x_inc_load = INC_W'(x_size_dir) * INC_W'(dy);
        y_inc_load = INC_W'(y_size_dir) * INC_W'(dx);
        if (!dx_neg)
        begin
            quad_load = dy_neg ? lpi_pkg::QUAD_4 : lpi_pkg::QUAD_1;
        end
        else
        begin
            quad_load = dy_neg ? lpi_pkg::QUAD_3 : lpi_pkg::QUAD_2;
        end
    end

    // ---------------- step ----------------
    always_comb
    begin
        x_neg = (quad_reg == lpi_pkg::QUAD_2) || (quad_reg == lpi_pkg::QUAD_3);
        y_neg = (quad_reg == lpi_pkg::QUAD_3) || (quad_reg == lpi_pkg::QUAD_4);

        if (first_reg)
        begin
            move_y = 1'b0;
        end
        else if ((quad_reg == lpi_pkg::QUAD_1) || (quad_reg == lpi_pkg::QUAD_3))
        begin
            move_y = !dev_reg[DEV_W-1];
        end
        else
        begin
            move_y = dev_reg[DEV_W-1] || (dev_reg == '0);
        end

        x_ext  = SUM_W'(pos_x_reg);
        y_ext  = SUM_W'(pos_y_reg);
        tx_ext = SUM_W'(target_x_reg);
        ty_ext = SUM_W'(target_y_reg);
        x_sz   = SUM_W'(x_step_size);
        y_sz   = SUM_W'(y_step_size);

        if (move_y)
        begin
            nx       = x_ext;
            ny       = y_neg ? (y_ext - y_sz) : (y_ext + y_sz);
            dev_step = dev_reg + DEV_W'(y_inc_reg);
        end
        else
        begin
            nx       = x_neg ? (x_ext - x_sz) : (x_ext + x_sz);
            ny       = y_ext;
            dev_step = dev_reg + DEV_W'(x_inc_reg);
        end

        // Test the pass on the exact coordinate, before saturation
        passed = (x_neg ? (nx < tx_ext) : (nx > tx_ext))
              || (y_neg ? (ny < ty_ext) : (ny > ty_ext));

        if (nx > COORD_MAX)
        begin
            sat_x = COORD_MAX[COORD_WIDTH-1:0];
        end
        else if (nx < COORD_MIN)
        begin
            sat_x = COORD_MIN[COORD_WIDTH-1:0];
        end
        else
        begin
            sat_x = nx[COORD_WIDTH-1:0];
        end

        if (ny > COORD_MAX)
        begin
            sat_y = COORD_MAX[COORD_WIDTH-1:0];
        end
        else if (ny < COORD_MIN)
        begin
            sat_y = COORD_MIN[COORD_WIDTH-1:0];
        end
        else
        begin
            sat_y = ny[COORD_WIDTH-1:0];
        end
    end

    // Result of a step item; an idle step reports no move
    always_comb
    begin
        flags.moved         = active_reg;
        flags.move_axis     = active_reg && move_y;
        flags.move_negative = active_reg && (move_y ? y_neg : x_neg);
        flags.last          = active_reg && passed;
        step_pos_x          = active_reg ? sat_x : pos_x_reg;
        step_pos_y          = active_reg ? sat_y : pos_y_reg;
    end

    // ---------------- next state ----------------
    always_comb
    begin
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        target_x_next = target_x_reg;
        target_y_next = target_y_reg;
        dev_next      = dev_reg;
        x_inc_next    = x_inc_reg;
        y_inc_next    = y_inc_reg;
        quad_next     = quad_reg;
        active_next   = active_reg;
        first_next    = first_reg;

        if (fire)
        begin
            if (func == lpi_pkg::FUNC_LOAD)
            begin
                pos_x_next    = seg_start_x;
                pos_y_next    = seg_start_y;
                target_x_next = seg_end_x;
                target_y_next = seg_end_y;
                dev_next      = '0;
                x_inc_next    = x_inc_load;
                y_inc_next    = y_inc_load;
                quad_next     = quad_load;
                active_next   = 1'b1;
                first_next    = 1'b1;
            end
            else if (active_reg)
            begin
                pos_x_next  = sat_x;
                pos_y_next  = sat_y;
                dev_next    = dev_step;
                first_next  = 1'b0;
                active_next = !passed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            target_x_reg <= '0;
            target_y_reg <= '0;
            dev_reg      <= '0;
            x_inc_reg    <= '0;
            y_inc_reg    <= '0;
            quad_reg     <= lpi_pkg::QUAD_1;
            active_reg   <= 1'b0;
            first_reg    <= 1'b0;
        end
        else
        begin
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            target_x_reg <= target_x_next;
            target_y_reg <= target_y_next;
            dev_reg      <= dev_next;
            x_inc_reg    <= x_inc_next;
            y_inc_reg    <= y_inc_next;
            quad_reg     <= quad_next;
            active_reg   <= active_next;
            first_reg    <= first_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/lpi_out_stage.sv */
// ---------------------------------------------------------------------------
// lpi_out_stage
// Result register: holds one result beat until the consumer takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module lpi_out_stage #(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          capture,
    input  wire lpi_pkg::move_flags_t          flags_in,
    input  wire logic signed [COORD_WIDTH-1:0] pos_x_in,
    input  wire logic signed [COORD_WIDTH-1:0] pos_y_in,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output lpi_pkg::move_flags_t               flags_out,
    output logic signed [COORD_WIDTH-1:0]      pos_x_out,
    output logic signed [COORD_WIDTH-1:0]      pos_y_out
);

    logic                          valid_reg;
    logic                          valid_next;
    lpi_pkg::move_flags_t          flags_reg;
    logic signed [COORD_WIDTH-1:0] pos_x_reg;
    logic signed [COORD_WIDTH-1:0] pos_y_reg;

    always_comb
    begin
        if (capture)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            flags_reg <= flags_in;
            pos_x_reg <= pos_x_in;
            pos_y_reg <= pos_y_in;
        end
    end

    assign out_valid = valid_reg;
    assign flags_out = flags_reg;
    assign pos_x_out = pos_x_reg;
    assign pos_y_out = pos_y_reg;

endmodule

`default_nettype wire

/* rtl/lpi_checker.sv */
// ---------------------------------------------------------------------------
// lpi_checker
// Port-level checks of the interpolator, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "linear_point_by_point_interpolator_top_defines.svh"

module lpi_checker #(
    parameter int COORD_WIDTH = 24
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic                          moved,
    input wire logic                          move_axis,
    input wire logic                          move_negative,
    input wire logic signed [COORD_WIDTH-1:0] pos_x,
    input wire logic signed [COORD_WIDTH-1:0] pos_y,
    input wire logic                          last
);

    logic                     out_stall;
    logic                     idle_beat;
    logic                     any_flag;
    logic [2*COORD_WIDTH+3:0] out_beat;

    assign out_stall = out_valid && !out_ready;
    assign idle_beat = out_valid && !moved;
    assign any_flag  = move_axis || move_negative || last;
    assign out_beat  = {moved, move_axis, move_negative, last, pos_x, pos_y};

    // A stalled result beat stays and keeps its payload
    `LPI_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_beat), "stalled beat changed")

    // A step without a segment reports no move, no direction and no end
    `LPI_ASSERT_NOW(a_idle_flags, idle_beat, !any_flag, "flags set on an idle beat")

    // Input backpressure only comes from a stalled result
    `LPI_ASSERT_NOW(a_ready_stall, !in_ready, out_stall, "input stalled with a free slot")

    // Nothing is offered right after reset
    `LPI_ASSERT_NOW(a_reset_empty, $rose(rst_n), !out_valid, "result beat present after reset")

endmodule

bind linear_point_by_point_interpolator_top lpi_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_lpi_checker (.*);

`default_nettype wire
